// ===== rtl/core/embc_pkg.sv =====
package embc_pkg;

	localparam int COUNT_WIDTH_DEF = 16;
	localparam int MAG_WIDTH       = 15;
	localparam int MAG_MAX         = 32767;
	localparam int TIMER_WIDTH     = 16;
	localparam int CFG_IDX_WIDTH   = 2;
	localparam int CFG_DATA_WIDTH  = 16;

	localparam logic [TIMER_WIDTH-1:0] TIMEOUT_RESET = 16'd1000;
	localparam logic [1:0]             ENABLE_RESET  = 2'b11;

	// configuration register indexes
	localparam logic [CFG_IDX_WIDTH-1:0] CFG_IDLE_TIMEOUT   = 2'd0;
	localparam logic [CFG_IDX_WIDTH-1:0] CFG_ENCODER_ENABLE = 2'd1;

	// item commands
	localparam logic CMD_EDGE = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	// report sources
	localparam logic [1:0] SRC_NONE = 2'd0;
	localparam logic [1:0] SRC_ENC1 = 2'd1;
	localparam logic [1:0] SRC_ENC2 = 2'd2;

	typedef struct packed {
		logic       cmd;
		logic [1:0] edge_line;
		logic       other_phase_active;
	} item_t;

	typedef struct packed {
		logic                 report_valid;
		logic [1:0]           source;
		logic                 counter_clockwise;
		logic [MAG_WIDTH-1:0] magnitude;
	} result_t;

	typedef struct packed {
		logic    push;
		result_t res;
	} result_push_t;

endpackage

// ===== rtl/core/encoder_motion_burst_counter_top.sv =====
// Motion burst counter for two quadrature encoders.
// Item channel (item_valid/item_ready/item): each item is an edge event
// (cmd = edge) naming one of four encoder lines, or a time tick. Edges on an
// enabled encoder with the opposite phase inactive step its saturating
// counter and restart the idle timer; ticks advance the timer while a burst
// is active.
// Result channel (result_valid/result_ready/result): one report per burst,
// produced on the tick that reaches the idle timeout. Encoder one is reported
// first if nonzero, else encoder two, else an all-zero "no motion" report.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): index 0 is the
// idle timeout in ticks, index 1 the encoder enable mask. Always ready; write
// only while no item is in flight. Other indexes are dropped.
// An item is registered at acceptance and evaluated while the result queue
// has room; at that edge its report is pushed into the queue, visible from
// then on. Throughput: one item per cycle while that queue has room.
// A two-entry result queue lets items keep flowing while the receiver stalls;
// the input stage holds only when that queue is full.
// Reset (arst_n low): counters, timer and queue clear, timeout returns to
// 1000 ticks and both encoders are enabled.
module encoder_motion_burst_counter_top import embc_pkg::*; #(
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      item_valid,
	output logic                      item_ready,
	input  item_t                     item,
	output logic                      result_valid,
	input  logic                      result_ready,
	output result_t                   result,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CFG_IDX_WIDTH-1:0]  cfg_index,
	input  logic [CFG_DATA_WIDTH-1:0] cfg_data
);

	logic         valid_s1;
	item_t        item_s1;
	logic         q_full;
	logic         proc;
	result_push_t push;

	// the s1 item is evaluated whenever the result queue has room
	assign proc       = valid_s1 && !q_full;
	assign item_ready = !valid_s1 || proc;
	assign cfg_ready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	// payload register, no reset needed
	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1 <= item;
		end
	end

	embc_core #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid && cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.proc     (proc),
		.item_s1  (item_s1),
		.out_push (push)
	);

	embc_outq u_outq (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_push     (push),
		.full        (q_full),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result      (result)
	);

`ifndef SYNTHESIS
	// a stalled s1 item must stay put until it is evaluated
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !proc) |=> (valid_s1 && $stable(item_s1)))
		else $error("s1 item lost or changed while stalled");

	// no report may be written into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push.push |-> !q_full)
		else $error("result queue overflow");

	// a pushed report shows up on the result channel next cycle
	a_push_visible: assert property (@(posedge clk) disable iff (!arst_n)
		push.push |=> result_valid)
		else $error("pushed report not visible");

	// reports only come from ticks
	a_tick_only: assert property (@(posedge clk) disable iff (!arst_n)
		push.push |-> (item_s1.cmd == CMD_TICK))
		else $error("report produced by an edge item");
`endif

endmodule

// ===== rtl/core/embc_core.sv =====
module embc_core import embc_pkg::*; #(
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_valid,
	input  logic [CFG_IDX_WIDTH-1:0]  cfg_index,
	input  logic [CFG_DATA_WIDTH-1:0] cfg_data,
	input  logic                      proc,
	input  item_t                     item_s1,
	output result_push_t              out_push
);

	localparam int EXT_WIDTH = (COUNT_WIDTH > MAG_WIDTH) ? COUNT_WIDTH : MAG_WIDTH + 1;
	localparam logic signed [COUNT_WIDTH-1:0] CNT_POS = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
	localparam logic signed [COUNT_WIDTH-1:0] CNT_NEG = -CNT_POS;

	logic [TIMER_WIDTH-1:0]          timeout_q;
	logic [1:0]                      enable_q;
	logic signed [COUNT_WIDTH-1:0]   count_one_q, count_two_q;
	logic                            burst_q;
	logic [TIMER_WIDTH-1:0]          timer_q;

	logic                            second, up, accept_edge, is_tick, timeout_hit;
	logic signed [COUNT_WIDTH-1:0]   sel_cnt, bumped, rep_cnt, abs_cnt;
	logic [TIMER_WIDTH-1:0]          timer_inc, eff_timeout;
	logic [EXT_WIDTH-1:0]            abs_ext;
	logic                            one_nz, two_nz;

	always_comb begin
		second      = item_s1.edge_line[1];
		up          = item_s1.edge_line[0];
		accept_edge = (item_s1.cmd == CMD_EDGE) && enable_q[second] &&
			!item_s1.other_phase_active;
		is_tick     = (item_s1.cmd == CMD_TICK) && burst_q;

		sel_cnt = second ? count_two_q : count_one_q;
		if (up) begin
			bumped = (sel_cnt != CNT_POS) ? sel_cnt + 1'b1 : sel_cnt;
		end else begin
			bumped = (sel_cnt != CNT_NEG) ? sel_cnt - 1'b1 : sel_cnt;
		end

		timer_inc   = (timer_q != '1) ? timer_q + 1'b1 : timer_q;
		eff_timeout = (timeout_q == '0) ? TIMER_WIDTH'(1) : timeout_q;
		timeout_hit = is_tick && (timer_inc >= eff_timeout);

		one_nz  = (count_one_q != '0);
		two_nz  = (count_two_q != '0);
		rep_cnt = one_nz ? count_one_q : count_two_q;
		// counters never reach the most negative code, so negation is safe
		abs_cnt = rep_cnt[COUNT_WIDTH-1] ? -rep_cnt : rep_cnt;
		abs_ext = EXT_WIDTH'($unsigned(abs_cnt));

		out_push.push = proc && timeout_hit;
		if (one_nz || two_nz) begin
			out_push.res.report_valid      = 1'b1;
			out_push.res.source            = one_nz ? SRC_ENC1 : SRC_ENC2;
			out_push.res.counter_clockwise = !rep_cnt[COUNT_WIDTH-1];
			out_push.res.magnitude         = (abs_ext > EXT_WIDTH'(MAG_MAX)) ?
				MAG_WIDTH'(MAG_MAX) : abs_ext[MAG_WIDTH-1:0];
		end else begin
			out_push.res.report_valid      = 1'b0;
			out_push.res.source            = SRC_NONE;
			out_push.res.counter_clockwise = 1'b0;
			out_push.res.magnitude         = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q   <= TIMEOUT_RESET;
			enable_q    <= ENABLE_RESET;
			count_one_q <= '0;
			count_two_q <= '0;
			burst_q     <= 1'b0;
			timer_q     <= '0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					CFG_IDLE_TIMEOUT:   timeout_q <= cfg_data;
					CFG_ENCODER_ENABLE: enable_q  <= cfg_data[1:0];
					default: ;
				endcase
			end
			if (proc && accept_edge) begin
				if (second) begin
					count_two_q <= bumped;
				end else begin
					count_one_q <= bumped;
				end
				burst_q <= 1'b1;
				timer_q <= '0;
			end else if (proc && is_tick) begin
				if (timeout_hit) begin
					burst_q <= 1'b0;
					timer_q <= '0;
					if (one_nz) begin
						count_one_q <= '0;
					end else if (two_nz) begin
						count_two_q <= '0;
					end
				end else begin
					timer_q <= timer_inc;
				end
			end
		end
	end

endmodule

// ===== rtl/core/embc_outq.sv =====
module embc_outq import embc_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  result_push_t in_push,
	output logic         full,
	output logic         result_valid,
	input  logic         result_ready,
	output result_t      result
);

	result_t    ent_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;
	logic       pop;

	assign full         = (count_q == 2'd2);
	assign result_valid = (count_q != 2'd0);
	assign result       = ent_q[rd_ptr_q];
	assign pop          = result_valid && result_ready;

	always_ff @(posedge clk) begin
		if (in_push.push) begin
			ent_q[wr_ptr_q] <= in_push.res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (in_push.push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({in_push.push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
	import embc_pkg::*;

	// counter width under test and its saturation limit
	localparam int COUNT_W     = COUNT_WIDTH_DEF;
	localparam int COUNT_LIMIT = (1 << (COUNT_W - 1)) - 1;

	// encoder lines carried in item.edge_line
	localparam logic [1:0] LINE_ENC1_DOWN = 2'd0;
	localparam logic [1:0] LINE_ENC1_UP   = 2'd1;
	localparam logic [1:0] LINE_ENC2_DOWN = 2'd2;
	localparam logic [1:0] LINE_ENC2_UP   = 2'd3;

	// encoder enable masks
	localparam logic [1:0] EN_NONE = 2'b00;
	localparam logic [1:0] EN_ENC1 = 2'b01;
	localparam logic [1:0] EN_ENC2 = 2'b10;
	localparam logic [1:0] EN_BOTH = 2'b11;

	// register indexes with no register behind them
	localparam logic [CFG_IDX_WIDTH-1:0] CFG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_WIDTH-1:0] CFG_SPARE_B = 2'd3;

	// cycles let pass after the last report before touching the registers;
	// this leaves margin for the block to empty
	localparam int DRAIN_CYCLES = 8;
	// receiver hold-off used to back the block up
	localparam int HOLD_CYCLES  = 400;
	// ticks sent under the reset timeout, well short of it
	localparam int RESET_PROBE_TICKS = 20;

	logic                      clk;
	logic                      arst_n;
	logic                      item_valid;
	logic                      item_ready;
	item_t                     item;
	logic                      result_valid;
	logic                      result_ready;
	result_t                   result;
	logic                      cfg_valid;
	logic                      cfg_ready;
	logic [CFG_IDX_WIDTH-1:0]  cfg_index;
	logic [CFG_DATA_WIDTH-1:0] cfg_data;

	encoder_motion_burst_counter_top #(
		.COUNT_WIDTH(COUNT_W)
	) i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.item        (item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result      (result),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Burst predictor: shadow registers and state of the block
	// ------------------------------------------------------------------
	logic [TIMER_WIDTH-1:0]    timeout_reg = TIMEOUT_RESET;
	logic [1:0]                enable_reg  = ENABLE_RESET;
	logic signed [COUNT_W-1:0] enc1_count  = '0;
	logic signed [COUNT_W-1:0] enc2_count  = '0;
	logic                      burst_on    = 1'b0;
	logic [TIMER_WIDTH-1:0]    idle_ticks  = '0;

	// reports the block still owes us, oldest first
	result_t pending_reports[$];
	int      fail_count = 0;

	// idling per cycle, in percent; hold-off count owned by the receiver loop
	int send_idle_pct = 13;
	int recv_idle_pct = 68;
	int rx_hold_left  = 0;

	// saturating up/down step of one encoder counter
	function automatic logic signed [COUNT_W-1:0] step_count(
		logic signed [COUNT_W-1:0] c, logic up);
		if (up)
			return (c < COUNT_LIMIT) ? COUNT_W'(c + 1) : COUNT_W'(COUNT_LIMIT);
		return (c > -COUNT_LIMIT) ? COUNT_W'(c - 1) : COUNT_W'(-COUNT_LIMIT);
	endfunction

	function automatic result_t make_report(logic [1:0] src, logic signed [COUNT_W-1:0] c);
		result_t r;
		int      mag;
		mag = int'(c);
		if (mag < 0)
			mag = -mag;
		if (mag > MAG_MAX)
			mag = MAG_MAX;
		r.report_valid      = 1'b1;
		r.source            = src;
		r.counter_clockwise = (c > 0);
		r.magnitude         = mag[MAG_WIDTH-1:0];
		return r;
	endfunction

	// advance the shadow state by one accepted item, queue any report it ends in
	function automatic void predict_item(item_t it);
		logic    second;
		logic    up;
		result_t r;
		if (it.cmd == CMD_EDGE) begin
			second = it.edge_line[1];
			up     = it.edge_line[0];
			// disabled encoder or opposite phase active: edge is dropped
			if (!enable_reg[second] || it.other_phase_active)
				return;
			if (second)
				enc2_count = step_count(enc2_count, up);
			else
				enc1_count = step_count(enc1_count, up);
			burst_on   = 1'b1;
			idle_ticks = '0;
			return;
		end
		// tick with no burst running does nothing
		if (!burst_on)
			return;
		if (idle_ticks != '1)
			idle_ticks++;
		// a timeout of zero behaves as one: the compare passes on the first tick
		if (idle_ticks < timeout_reg)
			return;
		burst_on   = 1'b0;
		idle_ticks = '0;
		// encoder one wins; the other counter is kept for a later burst
		if (enc1_count != 0) begin
			r          = make_report(SRC_ENC1, enc1_count);
			enc1_count = '0;
		end else if (enc2_count != 0) begin
			r          = make_report(SRC_ENC2, enc2_count);
			enc2_count = '0;
		end else begin
			// no motion report
			r        = '0;
			r.source = SRC_NONE;
		end
		pending_reports.push_back(r);
	endfunction

	// ------------------------------------------------------------------
	// Item sender and register writer
	// ------------------------------------------------------------------
	// offer one item, hold it until accepted, then feed the predictor
	task automatic send_item(item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item       <= it;
		do @(posedge clk); while (!item_ready);
		predict_item(it);
	endtask

	task automatic send_edge(logic [1:0] line, logic other);
		item_t it;
		it.cmd                = CMD_EDGE;
		it.edge_line          = line;
		it.other_phase_active = other;
		send_item(it);
	endtask

	// ticks carry random don't-care line/phase bits
	task automatic send_ticks(int n);
		item_t it;
		repeat (n) begin
			it.cmd                = CMD_TICK;
			it.edge_line          = 2'($urandom_range(3));
			it.other_phase_active = 1'($urandom_range(1));
			send_item(it);
		end
	endtask

	// stop offering, wait for every owed report, then let the pipe empty
	task automatic settle();
		item_valid <= 1'b0;
		@(posedge clk);
		while (pending_reports.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// register writes only ever happen with the block quiet
	task automatic write_reg(logic [CFG_IDX_WIDTH-1:0] idx, logic [CFG_DATA_WIDTH-1:0] data);
		settle();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_IDLE_TIMEOUT:   timeout_reg = data;
			CFG_ENCODER_ENABLE: enable_reg  = data[1:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Receiver: random ready, with an optional long hold-off
	// ------------------------------------------------------------------
	initial begin
		result_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (rx_hold_left > 0) begin
				rx_hold_left--;
				result_ready <= 1'b0;
			end else begin
				result_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// ------------------------------------------------------------------
	// Report checker
	// ------------------------------------------------------------------
	task automatic check_field(string name, int want, int got);
		if (want != got) begin
			fail_count++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin
		result_t want;
		if (arst_n && result_valid && result_ready) begin
			if (pending_reports.size() == 0) begin
				fail_count++;
				$display("%0t: unexpected report, expected none, actual %p", $time, result);
			end else begin
				want = pending_reports.pop_front();
				check_field("report_valid", want.report_valid, result.report_valid);
				check_field("source", want.source, result.source);
				check_field("counter_clockwise", want.counter_clockwise,
					result.counter_clockwise);
				check_field("magnitude", want.magnitude, result.magnitude);
			end
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------
	// both encoders enabled out of reset and the reset timeout is long:
	// a burst survives the probe ticks, then a shorter timeout ends it with
	// the timer carried over
	task automatic test_reset_defaults();
		send_edge(LINE_ENC1_UP, 1'b0);
		send_edge(LINE_ENC2_DOWN, 1'b0);
		send_ticks(RESET_PROBE_TICKS);
		write_reg(CFG_IDLE_TIMEOUT, 16'(RESET_PROBE_TICKS + 5));
		send_ticks(5);
		settle();
	endtask

	// hand-picked short sequences for each corner of the counting rules
	task automatic test_directed();
		write_reg(CFG_IDLE_TIMEOUT, 16'd2);
		// upper data bits are don't-care for the enable mask
		write_reg(CFG_ENCODER_ENABLE, {14'h3FFF, EN_BOTH});
		send_ticks(1);                       // tick while idle
		send_edge(LINE_ENC1_UP, 1'b0);
		send_edge(LINE_ENC1_UP, 1'b0);
		send_edge(LINE_ENC1_UP, 1'b1);       // opposite phase active, dropped
		send_ticks(2);
		send_edge(LINE_ENC2_DOWN, 1'b0);
		send_edge(LINE_ENC1_DOWN, 1'b0);
		send_ticks(2);                       // enc1 reported, enc2 held
		send_edge(LINE_ENC2_DOWN, 1'b1);
		send_ticks(1);                       // dropped edge, tick stays idle
		send_edge(LINE_ENC2_DOWN, 1'b0);
		send_ticks(2);                       // held enc2 count comes out
		send_edge(LINE_ENC1_UP, 1'b0);
		send_edge(LINE_ENC1_DOWN, 1'b0);
		send_ticks(2);                       // net zero: no motion report
		write_reg(CFG_ENCODER_ENABLE, {14'h0000, EN_ENC2});
		send_edge(LINE_ENC1_UP, 1'b0);
		send_edge(LINE_ENC2_UP, 1'b0);
		send_ticks(2);
		write_reg(CFG_ENCODER_ENABLE, {14'h0000, EN_NONE});
		send_edge(LINE_ENC1_DOWN, 1'b0);
		send_edge(LINE_ENC2_UP, 1'b0);
		send_ticks(1);
		// zero timeout acts as one tick
		write_reg(CFG_ENCODER_ENABLE, {14'h2AAA, EN_ENC1});
		write_reg(CFG_IDLE_TIMEOUT, 16'd0);
		send_edge(LINE_ENC2_UP, 1'b0);
		send_edge(LINE_ENC1_UP, 1'b0);
		send_ticks(1);
		settle();
	endtask

	// writes to unused indexes must leave both registers alone
	task automatic test_spare_index();
		write_reg(CFG_IDLE_TIMEOUT, 16'd3);
		write_reg(CFG_ENCODER_ENABLE, {14'h1555, EN_BOTH});
		write_reg(CFG_SPARE_A, 16'hFFFF);
		write_reg(CFG_SPARE_B, 16'h0000);
		send_edge(LINE_ENC2_UP, 1'b0);
		send_edge(LINE_ENC1_DOWN, 1'b0);
		send_ticks(3);
		settle();
	endtask

	// well-formed bursts with random content plus some noise, per idle mode
	task automatic test_random_bursts();
		item_t      it;
		logic [3:0] raw;
		int         sent;
		int         n;
		int         ticks;
		int         span;
		for (int mode = 0; mode < 3; mode++) begin
			case (mode)
				0: begin send_idle_pct = 13; recv_idle_pct = 68; end
				1: begin send_idle_pct = 68; recv_idle_pct = 13; end
				default: begin send_idle_pct = 0; recv_idle_pct = 0; end
			endcase
			repeat (4) begin
				if ($urandom_range(3) == 0)
					write_reg(CFG_IDLE_TIMEOUT, 16'($urandom_range(12)));
				else
					write_reg(CFG_IDLE_TIMEOUT, 16'($urandom_range(1, 6)));
				if ($urandom_range(9) < 6)
					write_reg(CFG_ENCODER_ENABLE, {14'($urandom), EN_BOTH});
				else
					write_reg(CFG_ENCODER_ENABLE, {14'($urandom), 2'($urandom_range(3))});
				sent = 0;
				while (sent < 80) begin
					if ($urandom_range(9) == 0) begin
						// raw noise item
						raw = 4'($urandom_range(15));
						it  = raw;
						send_item(it);
						sent++;
					end else begin
						n = $urandom_range(1, 6);
						repeat (n)
							send_edge(2'($urandom_range(3)), ($urandom_range(99) < 15));
						span  = (timeout_reg == 0) ? 1 : int'(timeout_reg);
						// some bursts are cut short and run into the next one
						ticks = ($urandom_range(4) == 0) ? $urandom_range(span) : span;
						send_ticks(ticks);
						sent += n + ticks;
					end
				end
			end
		end
		settle();
	endtask

	// receiver stalls long while reports keep coming, input must back up
	task automatic test_backpressure();
		write_reg(CFG_IDLE_TIMEOUT, 16'd1);
		write_reg(CFG_ENCODER_ENABLE, {14'h0000, EN_BOTH});
		rx_hold_left = HOLD_CYCLES;
		repeat (40) begin
			send_edge(2'($urandom_range(3)), 1'b0);
			send_ticks(1);
		end
		settle();
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		arst_n     = 1'b0;
		item_valid = 1'b0;
		item       = '0;
		cfg_valid  = 1'b0;
		cfg_index  = '0;
		cfg_data   = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_directed();
		test_spare_index();
		test_random_bursts();
		// long runs with no idling on either side
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_backpressure();

		settle();
		if (fail_count == 0 && pending_reports.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// hang guard, far beyond the slowest passing run
	initial begin
		#2_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
